[sv/sequence_reorder_buffer_assert.svh]
// Assertion macros for the sequence reorder buffer, used by sqrb_dp.
// Depends on nothing; included by the files that carry assertions.
`ifndef SEQUENCE_REORDER_BUFFER_ASSERT_SVH
`define SEQUENCE_REORDER_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQRB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sqrb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SQRB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sqrb assertion failed");

`endif

[sv/sqrb_pkg.sv]
// Shared types and constants for the sequence reorder buffer.
// Used by the controller, the datapath and the top level; depends on nothing.
package sqrb_pkg;

    // Fixed field widths of the request and result channels.
    localparam int SEQ_W    = 16;
    localparam int HANDLE_W = 32;
    localparam int LEN_W    = 16;

    // Defaults for the top-level parameters.
    localparam int SLOT_COUNT_DEF = 16;
    localparam int SEQ_BITS_DEF   = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;     // capture the accepted request
        logic advance;     // bump the expected sequence number
        logic write_slot;  // park the held request in the first free slot
        logic scan;        // register the slot match vector
        logic emit;        // load the output register from the held block
        logic emit_ovf;    // result is an overflow drop
        logic emit_last;   // result is the last for this request
        logic release_hit; // free the matched slot and read its data
        logic load_slot;   // move the read slot data into the held block
    } sqrb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_order;  // held block carries the expected number
        logic free_any;  // at least one slot is free
        logic hit;       // a parked block matches the expected number
        logic out_free;  // output register can take a result this cycle
    } sqrb_status_t;

endpackage

[sv/sqrb_ctrl.sv]
// Controller state machine of the sequence reorder buffer.
// Depends on sqrb_pkg; drives sqrb_dp through command and status structs.
module sqrb_ctrl
    import sqrb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  sqrb_status_t status,
    output sqrb_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_LOOK,
        ST_FETCH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    assign s_ready = ready_reg;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.in_order) begin
                    cmd.advance = 1'b1;
                    state_next  = ST_SCAN;
                end else if (status.free_any) begin
                    cmd.write_slot = 1'b1;
                    state_next     = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_ovf  = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.scan   = 1'b1;
                state_next = ST_LOOK;
            end
            ST_LOOK: begin
                // Emit the held block; last when nothing parked follows it.
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = !status.hit;
                    if (status.hit) begin
                        cmd.release_hit = 1'b1;
                        cmd.advance     = 1'b1;
                        state_next      = ST_FETCH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FETCH: begin
                cmd.load_slot = 1'b1;
                cmd.scan      = 1'b1;
                state_next    = ST_LOOK;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

[sv/sqrb_dp.sv]
// Datapath of the sequence reorder buffer: slot table, counters, output register.
// Depends on sqrb_pkg and sequence_reorder_buffer_assert.svh; driven by sqrb_ctrl.
`include "sequence_reorder_buffer_assert.svh"

module sqrb_dp
    import sqrb_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SEQ_BITS   = SEQ_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sqrb_cmd_t           cmd,
    output sqrb_status_t        status,
    input  logic [SEQ_W-1:0]    s_sequence_req,
    input  logic [HANDLE_W-1:0] s_payload_handle,
    input  logic [LEN_W-1:0]    s_block_length,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SEQ_W-1:0]    m_out_sequence,
    output logic [HANDLE_W-1:0] m_out_handle,
    output logic [LEN_W-1:0]    m_out_length,
    output logic                m_overflow,
    output logic                m_last
);

    localparam int SLOT_W  = $clog2(SLOT_COUNT);
    localparam int DATA_W  = HANDLE_W + LEN_W;
    localparam int CMP_W   = (SEQ_BITS > SEQ_W) ? SEQ_BITS : SEQ_W;
    localparam logic [SEQ_W-1:0] SEQ_MASK =
        (SEQ_BITS >= SEQ_W) ? {SEQ_W{1'b1}} : SEQ_W'((64'd1 << SEQ_BITS) - 64'd1);

    // Slot table: tags and valid bits in flops, block data in a memory.
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [SEQ_W-1:0]      tag_reg [SLOT_COUNT];
    logic [DATA_W-1:0]     data_mem [SLOT_COUNT];
    logic [DATA_W-1:0]     rd_data_reg;

    logic [SEQ_BITS-1:0]   expected_reg;
    logic [SEQ_W-1:0]      pend_seq_reg;
    logic [HANDLE_W-1:0]   pend_handle_reg;
    logic [LEN_W-1:0]      pend_len_reg;
    logic [SLOT_COUNT-1:0] match_reg;
    logic [SLOT_W-1:0]     hit_idx_reg;

    logic                  m_valid_reg;
    logic [SEQ_W-1:0]      m_seq_reg;
    logic [HANDLE_W-1:0]   m_handle_reg;
    logic [LEN_W-1:0]      m_len_reg;
    logic                  m_ovf_reg;
    logic                  m_last_reg;

    logic [CMP_W-1:0]      expected_ext;
    logic [SLOT_W-1:0]     free_idx;
    logic [SLOT_W-1:0]     hit_idx;
    logic                  out_free;

    assign expected_ext = CMP_W'(expected_reg);
    assign out_free     = !m_valid_reg || m_ready;

    // Lowest free slot and lowest matching slot.
    always_comb begin
        free_idx = '0;
        hit_idx  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = SLOT_W'(i);
            end
            if (match_reg[i]) begin
                hit_idx = SLOT_W'(i);
            end
        end
    end

    assign status.in_order = (CMP_W'(pend_seq_reg) == expected_ext);
    assign status.free_any = !(&valid_reg);
    assign status.hit      = |match_reg;
    assign status.out_free = out_free;

    // Expected counter, valid bits and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg <= '0;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.advance) begin
                expected_reg <= expected_reg + 1'b1;
            end
            if (cmd.write_slot) begin
                valid_reg[free_idx] <= 1'b1;
            end
            if (cmd.release_hit) begin
                valid_reg[hit_idx] <= 1'b0;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Held block, match vector and slot tags.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            pend_seq_reg    <= s_sequence_req & SEQ_MASK;
            pend_handle_reg <= s_payload_handle;
            pend_len_reg    <= s_block_length;
        end else if (cmd.load_slot) begin
            pend_seq_reg    <= tag_reg[hit_idx_reg];
            pend_handle_reg <= rd_data_reg[HANDLE_W-1:0];
            pend_len_reg    <= rd_data_reg[DATA_W-1:HANDLE_W];
        end
        if (cmd.scan) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                match_reg[i] <= valid_reg[i] && (CMP_W'(tag_reg[i]) == expected_ext);
            end
        end
        if (cmd.write_slot) begin
            tag_reg[free_idx] <= pend_seq_reg;
        end
        if (cmd.release_hit) begin
            hit_idx_reg <= hit_idx;
        end
    end

    // Block data memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.write_slot) begin
            data_mem[free_idx] <= {pend_len_reg, pend_handle_reg};
        end
        if (cmd.release_hit) begin
            rd_data_reg <= data_mem[hit_idx];
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_seq_reg    <= pend_seq_reg;
            m_handle_reg <= pend_handle_reg;
            m_len_reg    <= pend_len_reg;
            m_ovf_reg    <= cmd.emit_ovf;
            m_last_reg   <= cmd.emit_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_sequence = m_seq_reg;
    assign m_out_handle   = m_handle_reg;
    assign m_out_length   = m_len_reg;
    assign m_overflow     = m_ovf_reg;
    assign m_last         = m_last_reg;

    // The output register is only loaded when it is empty or being drained.
    `SQRB_ASSERT_IMP(a_emit_room, aclk, aresetn, cmd.emit, out_free)
    // A released slot must be valid and hold the expected number.
    `SQRB_ASSERT_IMP(a_release_hit, aclk, aresetn, cmd.release_hit, status.hit && valid_reg[hit_idx])
    // Parking only happens for an out-of-order block with room in the table.
    `SQRB_ASSERT_IMP(a_park_ok, aclk, aresetn, cmd.write_slot, status.free_any && !status.in_order)
    // Slot data is moved into the held block right after its memory read.
    `SQRB_ASSERT_IMP(a_fetch_order, aclk, aresetn, cmd.load_slot, $past(cmd.release_hit))

endmodule

[sv/sequence_reorder_buffer.sv]
// Top level of the sequence reorder buffer.
// Depends on sqrb_pkg, sqrb_ctrl and sqrb_dp.
//
// Usage: requests arrive on the s_ channel (valid/ready) carrying a sequence
// number, a data handle and a byte length. Results leave on the m_ channel
// (valid/ready), one per cycle at most, in sequence order.
// A request with the expected number is released together with every parked
// block that follows it in sequence; m_last marks the final result of the
// request. Any other request is parked in the lowest free slot and gives no
// result. With the table full it gives one result with m_overflow and m_last
// set, and the block is dropped.
// Flow: a parked request holds s_ready low for one cycle while it is parked,
// after which the next request can be accepted. An in-order request passes
// through the CHECK, SCAN and LOOK states to the output register, and the
// next request is accepted once its last result is emitted; each further parked
// block follows via FETCH and LOOK, bounded by the match-then-read memory loop.
// Reset clears the expected number to zero, empties every slot and drops any
// result held in the output register. A stalled receiver holds the block in
// its current step; the held result stays on m_ until m_ready is seen.
module sequence_reorder_buffer
    import sqrb_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SEQ_BITS   = SEQ_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SEQ_W-1:0]    s_sequence_req,
    input  logic [HANDLE_W-1:0] s_payload_handle,
    input  logic [LEN_W-1:0]    s_block_length,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SEQ_W-1:0]    m_out_sequence,
    output logic [HANDLE_W-1:0] m_out_handle,
    output logic [LEN_W-1:0]    m_out_length,
    output logic                m_overflow,
    output logic                m_last
);

    sqrb_cmd_t    cmd;
    sqrb_status_t status;

    // Sequencing of each request.
    sqrb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Slot table, counters and output register.
    sqrb_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .SEQ_BITS   (SEQ_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_sequence_req   (s_sequence_req),
        .s_payload_handle (s_payload_handle),
        .s_block_length   (s_block_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_sequence   (m_out_sequence),
        .m_out_handle     (m_out_handle),
        .m_out_length     (m_out_length),
        .m_overflow       (m_overflow),
        .m_last           (m_last)
    );

endmodule

[tb/sqrb_release_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the sequence reorder buffer: predicts the in-order releases of
// every accepted request and compares them with the m_ channel. Uses sqrb_pkg.
module sqrb_release_checker
    import sqrb_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SEQ_BITS   = SEQ_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [SEQ_W-1:0]    s_sequence_req,
    input  logic [HANDLE_W-1:0] s_payload_handle,
    input  logic [LEN_W-1:0]    s_block_length,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [SEQ_W-1:0]    m_out_sequence,
    input  logic [HANDLE_W-1:0] m_out_handle,
    input  logic [LEN_W-1:0]    m_out_length,
    input  logic                m_overflow,
    input  logic                m_last,
    output int                  mismatches,
    output int                  outstanding
);

    localparam logic [31:0] SEQ_MASK =
        (SEQ_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << SEQ_BITS) - 64'd1);

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
        logic                overflow;
        logic                last;
    } release_t;

    // Shadow copy of the buffer state.
    logic [31:0]         next_in_order;
    logic                park_valid  [SLOT_COUNT];
    logic [31:0]         park_seq    [SLOT_COUNT];
    logic [HANDLE_W-1:0] park_handle [SLOT_COUNT];
    logic [LEN_W-1:0]    park_len    [SLOT_COUNT];

    release_t releases_due[$];
    release_t front;
    int       releases_seen  = 0;
    int       mismatch_total = 0;
    int       queued         = 0;
    int       k;

    assign mismatches  = mismatch_total;
    assign outstanding = queued;

    task automatic report_mismatch(input string detail);
        mismatch_total++;
        $display("%0t ns: %s", $time, detail);
    endtask

    // Lowest valid slot holding the given sequence number, or -1.
    function automatic int parked_match(input logic [31:0] seq);
        int i;
        int found;
        found = -1;
        for (i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (park_valid[i] && park_seq[i] == seq) begin
                found = i;
            end
        end
        return found;
    endfunction

    // Works out the releases caused by one request and queues them.
    task automatic predict_releases(input logic [SEQ_W-1:0] seq_in,
                                    input logic [HANDLE_W-1:0] handle,
                                    input logic [LEN_W-1:0] len);
        logic [31:0] seq;
        release_t    r;
        int          hit;
        int          i;
        bit          stored;
        seq = 32'(seq_in) & SEQ_MASK;
        stored = 1'b0;
        r.seq = seq[SEQ_W-1:0];
        r.handle = handle;
        r.len = len;
        r.overflow = 1'b0;
        r.last = 1'b0;
        if (seq == next_in_order) begin
            // In order: release it, then walk the parked blocks that follow.
            next_in_order = (next_in_order + 32'd1) & SEQ_MASK;
            hit = parked_match(next_in_order);
            while (hit >= 0) begin
                releases_due.push_back(r);
                r.seq = park_seq[hit][SEQ_W-1:0];
                r.handle = park_handle[hit];
                r.len = park_len[hit];
                park_valid[hit] = 1'b0;
                next_in_order = (next_in_order + 32'd1) & SEQ_MASK;
                hit = parked_match(next_in_order);
            end
            r.last = 1'b1;
            releases_due.push_back(r);
        end else begin
            // Out of order: park in the lowest free slot, or drop on a full table.
            for (i = 0; i < SLOT_COUNT; i++) begin
                if (!stored && !park_valid[i]) begin
                    park_valid[i] = 1'b1;
                    park_seq[i] = seq;
                    park_handle[i] = handle;
                    park_len[i] = len;
                    stored = 1'b1;
                end
            end
            if (!stored) begin
                r.overflow = 1'b1;
                r.last = 1'b1;
                releases_due.push_back(r);
            end
        end
    endtask

    // Predict on each accepted request, compare each accepted result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            next_in_order = '0;
            for (k = 0; k < SLOT_COUNT; k++) begin
                park_valid[k] = 1'b0;
            end
            releases_due.delete();
        end else begin
            if (s_valid && s_ready) begin
                predict_releases(s_sequence_req, s_payload_handle, s_block_length);
            end
            if (m_valid && m_ready) begin
                releases_seen++;
                if (releases_due.size() == 0) begin
                    report_mismatch($sformatf(
                        "release %0d with nothing expected: sequence %h handle %h",
                        releases_seen, m_out_sequence, m_out_handle));
                end else begin
                    front = releases_due.pop_front();
                    if (m_out_sequence !== front.seq) begin
                        report_mismatch($sformatf("release %0d sequence: got %h, expected %h",
                            releases_seen, m_out_sequence, front.seq));
                    end
                    if (m_out_handle !== front.handle) begin
                        report_mismatch($sformatf("release %0d handle: got %h, expected %h",
                            releases_seen, m_out_handle, front.handle));
                    end
                    if (m_out_length !== front.len) begin
                        report_mismatch($sformatf("release %0d length: got %h, expected %h",
                            releases_seen, m_out_length, front.len));
                    end
                    if (m_overflow !== front.overflow) begin
                        report_mismatch($sformatf("release %0d overflow: got %b, expected %b",
                            releases_seen, m_overflow, front.overflow));
                    end
                    if (m_last !== front.last) begin
                        report_mismatch($sformatf("release %0d last: got %b, expected %b",
                            releases_seen, m_last, front.last));
                    end
                end
            end
        end
        queued <= releases_due.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Top of the sequence reorder buffer testbench: clock, reset, request stimulus
// and verdict. Depends on sqrb_pkg, sequence_reorder_buffer, sqrb_release_checker.
module tb_top;
    import sqrb_pkg::*;

    localparam int RUN_LIMIT    = 2_000_000;
    localparam int RANDOM_ITEMS = 100;
    localparam int TAIL_CYCLES  = 40;
    localparam int STRAY_CAP    = 8;

    typedef enum int {
        BATCH_PLAIN,
        BATCH_WITH_COPY,
        BATCH_OVERFILL
    } batch_kind_t;

    logic                aclk             = 1'b0;
    logic                aresetn          = 1'b0;
    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic [SEQ_W-1:0]    s_sequence_req   = '0;
    logic [HANDLE_W-1:0] s_payload_handle = '0;
    logic [LEN_W-1:0]    s_block_length   = '0;
    logic                m_valid;
    logic                m_ready          = 1'b0;
    logic [SEQ_W-1:0]    m_out_sequence;
    logic [HANDLE_W-1:0] m_out_handle;
    logic [LEN_W-1:0]    m_out_length;
    logic                m_overflow;
    logic                m_last;

    int mismatch_count;
    int releases_pending;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int sent_items    = 0;

    // Stimulus bookkeeping: the next in-order number and the blocks parked
    // off the main stream, which the buffer passes over when it reaches them.
    logic [SEQ_W-1:0] next_seq = '0;
    logic [SEQ_W-1:0] strays[$];

    always #6 aclk = ~aclk;

    sequence_reorder_buffer uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sequence_req   (s_sequence_req),
        .s_payload_handle (s_payload_handle),
        .s_block_length   (s_block_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_sequence   (m_out_sequence),
        .m_out_handle     (m_out_handle),
        .m_out_length     (m_out_length),
        .m_overflow       (m_overflow),
        .m_last           (m_last)
    );

    sqrb_release_checker release_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sequence_req   (s_sequence_req),
        .s_payload_handle (s_payload_handle),
        .s_block_length   (s_block_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_sequence   (m_out_sequence),
        .m_out_handle     (m_out_handle),
        .m_out_length     (m_out_length),
        .m_overflow       (m_overflow),
        .m_last           (m_last),
        .mismatches       (mismatch_count),
        .outstanding      (releases_pending)
    );

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("sequence_reorder_buffer test failed");
            $finish;
        end
    end

    // Offers one request and returns at the edge where it is accepted.
    task automatic send_block(input logic [SEQ_W-1:0] seq,
                              input logic [HANDLE_W-1:0] handle,
                              input logic [LEN_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sequence_req <= seq;
        s_payload_handle <= handle;
        s_block_length <= len;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sent_items++;
    endtask

    // Stops sending and waits until every predicted release has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (releases_pending != 0);
    endtask

    // Takes the next stream number; strays reached on the way are released
    // by the buffer itself, so they are skipped here.
    function automatic logic [SEQ_W-1:0] claim_sequence();
        logic [SEQ_W-1:0] n;
        int i;
        n = next_seq;
        next_seq = next_seq + 1'b1;
        i = 0;
        while (i < strays.size()) begin
            if (strays[i] == next_seq) begin
                strays.delete(i);
                next_seq = next_seq + 1'b1;
                i = 0;
            end else begin
                i++;
            end
        end
        return n;
    endfunction

    // Sends a shuffled run of consecutive numbers. A copy run adds one
    // duplicate that ends up parked for good; an overfill run parks numbers
    // until the table is full, has the next number dropped, then releases all.
    task automatic send_batch(input int count, input batch_kind_t kind);
        logic [SEQ_W-1:0] order[$];
        logic [SEQ_W-1:0] swap_val;
        int lo;
        int i;
        int j;
        lo = (kind == BATCH_OVERFILL) ? 1 : 0;
        for (i = 0; i < count + lo; i++) begin
            order.push_back(claim_sequence());
        end
        for (i = order.size() - 1; i > lo; i--) begin
            j = $urandom_range(i, lo);
            swap_val = order[i];
            order[i] = order[j];
            order[j] = swap_val;
        end
        if (kind == BATCH_WITH_COPY) begin
            j = $urandom_range(order.size() - 1);
            strays.push_back(order[j]);
            order.insert($urandom_range(order.size()), order[j]);
        end
        for (i = lo; i < order.size(); i++) begin
            send_block(order[i], $urandom, 16'($urandom));
        end
        if (kind == BATCH_OVERFILL) begin
            send_block(next_seq, $urandom, 16'($urandom));
            send_block(order[0], $urandom, 16'($urandom));
        end
    endtask

    initial begin
        int i;
        int phase;
        int pick;
        int room;
        int goal;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: first in-order block with zero fields.
        send_block(16'd0, 32'h0000_0000, 16'h0000);
        // Fill every slot with blocks 17 down to 2, then overflow the table.
        for (i = 17; i >= 2; i--) begin
            send_block(16'(i), (i == 17) ? 32'hFFFF_FFFF : $urandom,
                       (i == 2) ? 16'hFFFF : 16'($urandom));
        end
        send_block(16'd100, 32'hFFFF_FFFF, 16'hFFFF);
        // The missing block releases the longest possible chain.
        send_block(16'd1, $urandom, 16'h0000);
        // Two parked blocks with the same number: the lower slot goes first.
        send_block(16'd20, 32'hAAAA_5555, 16'h1234);
        send_block(16'd20, 32'h5555_AAAA, 16'h4321);
        // A stale number and the largest number stay parked.
        send_block(16'd5, $urandom, 16'($urandom));
        send_block(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_block(16'd19, $urandom, 16'($urandom));
        send_block(16'd18, $urandom, 16'($urandom));
        next_seq = 16'd21;
        strays.push_back(16'd20);
        strays.push_back(16'd5);
        strays.push_back(16'hFFFF);
        wait_drained();

        // Random runs, one idling pattern per phase.
        sent_items = 0;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    send_idle_pct = 68;
                    stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct <= 68;
                end
                default: begin
                    send_idle_pct = 37;
                    stall_pct <= 37;
                end
            endcase
            goal = (phase + 1) * RANDOM_ITEMS / 4;
            while (sent_items < goal) begin
                pick = $urandom_range(99);
                room = SLOT_COUNT_DEF - strays.size();
                if (pick < 10) begin
                    send_batch(room, BATCH_OVERFILL);
                end else if (pick < 22 && strays.size() < STRAY_CAP) begin
                    // A stray number, either stale or far ahead.
                    if ($urandom_range(1)) begin
                        strays.push_back(next_seq - 16'($urandom_range(16'h7FFF, 1)));
                    end else begin
                        strays.push_back(next_seq + 16'($urandom_range(16'h7FFF, 16'h0400)));
                    end
                    send_block(strays[strays.size() - 1], $urandom, 16'($urandom));
                end else if (pick < 35 && strays.size() < STRAY_CAP) begin
                    send_batch($urandom_range((room - 1 < 8) ? room - 1 : 8, 1),
                               BATCH_WITH_COPY);
                end else begin
                    send_batch($urandom_range((room < 12) ? room : 12, 1), BATCH_PLAIN);
                end
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("sequence_reorder_buffer test passed");
        end else begin
            $display("sequence_reorder_buffer test failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/sqrb_pkg.sv
sv/sqrb_ctrl.sv
sv/sqrb_dp.sv
sv/sequence_reorder_buffer.sv
tb/sqrb_release_checker.sv
tb/tb_top.sv
